@@ sv/sso_pkg.sv @@
// Package: shared constants, microcode types and the quarter-wave sine table builder.
`timescale 1ns / 1ps
`default_nettype none
package sso_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int PHASE_BITS       = 32;
  localparam int IDX_BITS         = $clog2(SINE_TABLE_DEPTH);
  localparam int ADDR_BITS        = IDX_BITS + 1;
  localparam int FRAC_BITS        = PHASE_BITS - 2;
  localparam int PH_SHIFT         = 50 - PHASE_BITS;

  localparam int FREQ_W   = 22;
  localparam int AGAIN_W  = 15;
  localparam int COEF_W   = 16;
  localparam int PSTEP_W  = 24;
  localparam int STATE_W  = 32;
  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int MUL_A_W = STATE_W + 1;
  localparam int MUL_B_W = PSTEP_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int STEP_BITS = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_COEF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_COEF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_FREQ    = 3'd4;

  localparam logic [AGAIN_W-1:0] RST_ACTIVE_GAIN = 15'd4915;
  localparam logic [COEF_W-1:0]  RST_FREQ_COEF   = 16'd164;
  localparam logic [COEF_W-1:0]  RST_GAIN_COEF   = 16'd98;
  localparam logic [PSTEP_W-1:0] RST_PHASE_STEP  = 24'd97392;
  localparam logic [FREQ_W-1:0]  RST_INIT_FREQ   = 22'd113280;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FREQ,
    MUL_GAIN,
    MUL_SINE,
    MUL_STEP
  } mul_op_e;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_LATCH,
    WB_FREQ,
    WB_GAIN,
    WB_OUT,
    WB_PHASE
  } wb_op_e;

  typedef struct packed {
    wait_e                cond;
    mul_op_e              mul;
    wb_op_e               wb;
    logic                 jump;
    logic [STEP_BITS-1:0] target;
  } ucode_t;

  typedef struct packed {
    mul_op_e mul;
    wb_op_e  wb;
    logic    fire;
  } ctl_t;

  typedef logic [AGAIN_W-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  function automatic sine_tab_t sine_table();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      r;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[k]);
        if (k[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + 64'sd16384) >>> 15;
      if (r > 32767) begin
        r = 32767;
      end
      tab[i] = AGAIN_W'(r);
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

@@ sv/smoothed_sine_oscillator.sv @@
// Top level: smoothed sine oscillator, microcoded sequencer around a shared multiplier.
// Path: a beat latched at step 0 gets its sample into the output register at step 6.
// Throughput: one beat per pass of the 8-step program through the one multiplier; a new
// beat is taken only at step 0, and step 6 waits while the previous sample is stalled.
// Reset: asynchronous, active low; the config registers take their default values, the phase
// clears, the smoothed frequency takes the initial frequency; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module smoothed_sine_oscillator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sso_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [sso_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [sso_pkg::FREQ_W-1:0]      target_frequency_i,
  input  wire logic                            active_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [sso_pkg::SAMPLE_W-1:0]  sample_out_o
);
  import sso_pkg::*;

  ctl_t                 ctl;
  logic                 out_free;
  logic [ADDR_BITS-1:0] rom_addr;
  logic [AGAIN_W-1:0]   rom_data;

  sso_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl)
  );

  sso_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  sso_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (ctl),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .target_frequency_i (target_frequency_i),
    .active_i           (active_i),
    .out_stall_i        (out_stall_i),
    .rom_data_i         (rom_data),
    .rom_addr_o         (rom_addr),
    .out_free_o         (out_free),
    .out_valid_o        (out_valid_o),
    .sample_out_o       (sample_out_o)
  );

endmodule
`default_nettype wire

@@ sv/sso_rom.sv @@
// Quarter-wave sine ROM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sso_rom (
  input  wire logic                           clk_i,
  input  wire logic [sso_pkg::ADDR_BITS-1:0]  addr_i,
  output logic      [sso_pkg::AGAIN_W-1:0]    data_o
);
  import sso_pkg::*;

  localparam sine_tab_t SineRom = sine_table();

  logic [AGAIN_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= SineRom[addr_i];
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

@@ sv/sso_useq.sv @@
// Microcode sequencer: step counter, control store and wait/jump handling.
`timescale 1ns / 1ps
`default_nettype none
module sso_useq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          out_free_i,
  output logic               in_stall_o,
  output sso_pkg::ctl_t      ctl_o
);
  import sso_pkg::*;

  function automatic ucode_t ucode(input logic [STEP_BITS-1:0] s);
    ucode_t w;
    w = '{cond: WAIT_NONE, mul: MUL_NONE, wb: WB_NONE, jump: 1'b0, target: '0};
    case (s)
      3'd0: begin
        w.cond = WAIT_IN;
        w.wb   = WB_LATCH;
      end
      3'd1: w.mul = MUL_FREQ;
      3'd2: w.wb  = WB_FREQ;
      3'd3: w.mul = MUL_GAIN;
      3'd4: w.wb  = WB_GAIN;
      3'd5: w.mul = MUL_SINE;
      3'd6: begin
        w.cond = WAIT_OUT;
        w.mul  = MUL_STEP;
        w.wb   = WB_OUT;
      end
      3'd7: begin
        w.wb     = WB_PHASE;
        w.jump   = 1'b1;
        w.target = '0;
      end
      default: w.cond = WAIT_NONE;
    endcase
    return w;
  endfunction

  logic [STEP_BITS-1:0] step_q, step_d;
  ucode_t               uw;
  logic                 fire;

  always_comb begin
    uw = ucode(step_q);
    case (uw.cond)
      WAIT_IN:  fire = in_valid_i;
      WAIT_OUT: fire = out_free_i;
      default:  fire = 1'b1;
    endcase
    if (!fire) begin
      step_d = step_q;
    end else if (uw.jump) begin
      step_d = uw.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  assign in_stall_o = (uw.cond != WAIT_IN);
  assign ctl_o      = '{mul: uw.mul, wb: uw.wb, fire: fire};

endmodule
`default_nettype wire

@@ sv/sso_dp.sv @@
// Datapath: config registers, smoothing state, phase, shared multiplier, output register.
`timescale 1ns / 1ps
`default_nettype none
module sso_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire sso_pkg::ctl_t                   ctl_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [sso_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [sso_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic [sso_pkg::FREQ_W-1:0]      target_frequency_i,
  input  wire logic                            active_i,
  input  wire logic                            out_stall_i,
  input  wire logic [sso_pkg::AGAIN_W-1:0]     rom_data_i,
  output logic      [sso_pkg::ADDR_BITS-1:0]   rom_addr_o,
  output logic                                 out_free_o,
  output logic                                 out_valid_o,
  output logic signed [sso_pkg::SAMPLE_W-1:0]  sample_out_o
);
  import sso_pkg::*;

  logic [AGAIN_W-1:0]    ag_q;
  logic [COEF_W-1:0]     fc_q;
  logic [COEF_W-1:0]     gc_q;
  logic [PSTEP_W-1:0]    pstep_q;
  logic [FREQ_W-1:0]     tf_q;
  logic                  act_q;
  logic [STATE_W-1:0]    sf_q;
  logic [STATE_W-1:0]    sg_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       ovld_q;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic [STATE_W-1:0]         gain_tgt;
  logic [STATE_W-1:0]         freq_tgt;
  logic signed [MUL_B_W-1:0]  sine_mag;
  logic signed [PROD_W-1:0]   delta;
  logic signed [PROD_W-1:0]   scaled;
  logic signed [SAMPLE_W-1:0] sample_d;
  logic [IDX_BITS-1:0]        idx;

  // quadrant fold: odd quadrants read the table mirrored
  assign idx        = phase_q[FRAC_BITS-1 -: IDX_BITS];
  assign rom_addr_o = phase_q[FRAC_BITS] ? ADDR_BITS'(SINE_TABLE_DEPTH) - {1'b0, idx}
                                         : {1'b0, idx};

  always_comb begin
    freq_tgt = {tf_q, 10'b0};
    gain_tgt = act_q ? {1'b0, ag_q, 16'b0} : '0;
    sine_mag = {{(MUL_B_W-AGAIN_W){1'b0}}, rom_data_i};
    case (ctl_i.mul)
      MUL_FREQ: begin
        mul_a = $signed({1'b0, freq_tgt}) - $signed({1'b0, sf_q});
        mul_b = {{(MUL_B_W-COEF_W){1'b0}}, fc_q};
      end
      MUL_GAIN: begin
        mul_a = $signed({1'b0, gain_tgt}) - $signed({1'b0, sg_q});
        mul_b = {{(MUL_B_W-COEF_W){1'b0}}, gc_q};
      end
      MUL_SINE: begin
        mul_a = {1'b0, sg_q};
        mul_b = phase_q[PHASE_BITS-1] ? -sine_mag : sine_mag;
      end
      MUL_STEP: begin
        mul_a = {1'b0, sf_q};
        mul_b = {1'b0, pstep_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    delta  = prod_q >>> 16;
    scaled = prod_q >>> 31;
    if (scaled > PROD_W'(32767)) begin
      sample_d = 16'sh7FFF;
    end else if (scaled < -PROD_W'(32768)) begin
      sample_d = 16'sh8000;
    end else begin
      sample_d = scaled[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fire && ctl_i.mul != MUL_NONE) begin
      prod_q <= mul_a * mul_b;
    end
    if (ctl_i.fire && ctl_i.wb == WB_LATCH) begin
      tf_q  <= target_frequency_i;
      act_q <= active_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ag_q     <= RST_ACTIVE_GAIN;
      fc_q     <= RST_FREQ_COEF;
      gc_q     <= RST_GAIN_COEF;
      pstep_q  <= RST_PHASE_STEP;
      sf_q     <= {RST_INIT_FREQ, 10'b0};
      sg_q     <= '0;
      phase_q  <= '0;
      ovld_q   <= 1'b0;
      sample_q <= '0;
    end else begin
      // initial frequency only matters at reset, so its write is dropped
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ACTIVE_GAIN: ag_q    <= cfg_data_i[AGAIN_W-1:0];
          CFG_FREQ_COEF:   fc_q    <= cfg_data_i[COEF_W-1:0];
          CFG_GAIN_COEF:   gc_q    <= cfg_data_i[COEF_W-1:0];
          CFG_PHASE_STEP:  pstep_q <= cfg_data_i[PSTEP_W-1:0];
          default: ;
        endcase
      end
      if (ctl_i.fire) begin
        case (ctl_i.wb)
          WB_FREQ:  sf_q    <= sf_q + delta[STATE_W-1:0];
          WB_GAIN:  sg_q    <= sg_q + delta[STATE_W-1:0];
          WB_PHASE: phase_q <= phase_q + prod_q[PH_SHIFT +: PHASE_BITS];
          default: ;
        endcase
      end
      if (ctl_i.fire && ctl_i.wb == WB_OUT) begin
        ovld_q   <= 1'b1;
        sample_q <= sample_d;
      end else if (ovld_q && !out_stall_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  assign out_free_o   = !ovld_q || !out_stall_i;
  assign out_valid_o  = ovld_q;
  assign sample_out_o = sample_q;

endmodule
`default_nettype wire

@@ sv/sso_checker.sv @@
// Port-level checker for the oscillator and its bind.
`timescale 1ns / 1ps
`default_nettype none
module sso_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_stall_o,
  input  wire logic [sso_pkg::FREQ_W-1:0]      target_frequency_i,
  input  wire logic                            active_i,
  input  wire logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  input  wire logic [sso_pkg::SAMPLE_W-1:0]    sample_out_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // a stalled sample holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled output beat changed");

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(target_frequency_i)
                                 && $stable(active_i))
    else $error("stalled input beat changed");

  // one beat busies the input side for the rest of the program
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o ##1 in_stall_o ##1 in_stall_o ##1 in_stall_o
                ##1 in_stall_o ##1 in_stall_o)
    else $error("input taken mid-program");

  // every input beat is followed by a pending sample
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> ##7 out_valid_o)
    else $error("no sample after input beat");

  // register writes land only between programs
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_stall_o)
    else $error("register write during a program");

endmodule

bind smoothed_sine_oscillator sso_checker u_sso_checker (.*);
`default_nettype wire

@@ verif/tb_smoothed_sine_oscillator.sv @@
// Testbench for smoothed_sine_oscillator: random beats and settings against a local predictor.
`timescale 1ns / 1ps
module tb_smoothed_sine_oscillator;
  import sso_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              act;
  } tick_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_ACTIVE_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [FREQ_W-1:0]     target_frequency_i = '0;
  logic                  active_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out_o;

  smoothed_sine_oscillator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .target_frequency_i(target_frequency_i),
    .active_i          (active_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sample_out_o      (sample_out_o)
  );

  // oscillator model state and settings
  int                quarter_sine [0:SINE_TABLE_DEPTH];
  logic [STATE_W-1:0] osc_phase = '0;
  logic [STATE_W-1:0] osc_freq = STATE_W'(RST_INIT_FREQ) << 10;
  logic [STATE_W-1:0] osc_gain = '0;
  logic [AGAIN_W-1:0] set_gain = RST_ACTIVE_GAIN;
  logic [COEF_W-1:0]  set_fcoef = RST_FREQ_COEF;
  logic [COEF_W-1:0]  set_gcoef = RST_GAIN_COEF;
  logic [PSTEP_W-1:0] set_pstep = RST_PHASE_STEP;

  tick_t                      tick_queue [$];
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  int   err_count = 0;
  int   quiet = 0;
  int   in_gap = 0;
  int   stall_hold = 0;
  logic in_taken = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + 16384) >>> 15;
      if (sum > 32767) begin
        sum = 32767;
      end
      quarter_sine[i] = int'(sum);
    end
  end

  // one-pole step: cur + floor(coef * (tgt - cur) / 2^16)
  function automatic logic [STATE_W-1:0] glide(input logic [STATE_W-1:0] cur,
                                               input logic [STATE_W-1:0] tgt,
                                               input logic [COEF_W-1:0] coef);
    longint d;
    d = longint'(tgt) - longint'(cur);
    d = d * longint'(coef);
    return STATE_W'(longint'(cur) + (d >>> 16));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] osc_tick(input logic [FREQ_W-1:0] tf,
                                                          input logic act);
    int              idx;
    int              s;
    longint          p;
    longint unsigned inc;
    osc_freq = glide(osc_freq, STATE_W'(tf) << 10, set_fcoef);
    osc_gain = glide(osc_gain, act ? STATE_W'(set_gain) << 16 : '0, set_gcoef);
    idx = int'(osc_phase[FRAC_BITS-1 -: IDX_BITS]);
    if (osc_phase[FRAC_BITS]) begin
      idx = SINE_TABLE_DEPTH - idx;
    end
    s = quarter_sine[idx];
    if (osc_phase[FRAC_BITS+1]) begin
      s = -s;
    end
    p = (longint'(s) * longint'(osc_gain)) >>> 31;
    if (p > 32767) begin
      p = 32767;
    end else if (p < -32768) begin
      p = -32768;
    end
    inc = (64'(osc_freq) * 64'(set_pstep)) >> PH_SHIFT;
    osc_phase = osc_phase + STATE_W'(inc);
    return SAMPLE_W'(p);
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 60);
  endfunction

  task automatic push_tick(input logic [FREQ_W-1:0] f, input logic a);
    tick_t t;
    t.freq = f;
    t.act  = a;
    tick_queue.push_back(t);
  endtask

  // runs of held targets so the smoothing settles, with occasional single-beat noise
  task automatic queue_random(input int n);
    tick_t t;
    int    run;
    int    r;
    run    = 0;
    t.freq = FREQ_W'($urandom());
    t.act  = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      if (run == 0) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          t.freq = FREQ_W'($urandom_range(20, 5000) << 8);
        end else if (r < 75) begin
          t.freq = FREQ_W'($urandom());
        end else if (r < 85) begin
          t.freq = '0;
        end else if (r < 92) begin
          t.freq = '1;
        end else begin
          t.freq = FREQ_W'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 2) == 0) begin
          t.act = ~t.act;
        end
        run = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(4, 60);
      end
      run--;
      tick_queue.push_back(t);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ACTIVE_GAIN: set_gain = data[AGAIN_W-1:0];
      CFG_FREQ_COEF:   set_fcoef = data[COEF_W-1:0];
      CFG_GAIN_COEF:   set_gcoef = data[COEF_W-1:0];
      CFG_PHASE_STEP:  set_pstep = data[PSTEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] g, input logic [CFG_DATA_W-1:0] fc,
                           input logic [CFG_DATA_W-1:0] gc, input logic [CFG_DATA_W-1:0] ps,
                           input logic [CFG_DATA_W-1:0] fi);
    write_reg(CFG_ACTIVE_GAIN, g);
    write_reg(CFG_FREQ_COEF, fc);
    write_reg(CFG_GAIN_COEF, gc);
    write_reg(CFG_PHASE_STEP, ps);
    write_reg(CFG_INIT_FREQ, fi);
  endtask

  task automatic drain();
    while (tick_queue.size() != 0 || in_valid_i || expected_samples.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (16) @(posedge clk_i);
  endtask

  // input driver
  always @(negedge clk_i) begin
    tick_t t;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_gap > 0) begin
        in_gap     <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        t = tick_queue.pop_front();
        in_valid_i         <= 1'b1;
        target_frequency_i <= t.freq;
        active_i           <= t.act;
        in_gap             <= pick_idle();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk_i) begin
    int g;
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_hold  <= $urandom_range(0, 30);
    end else begin
      g = pick_idle();
      out_stall_i <= (g > 0);
      stall_hold  <= g;
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    logic signed [SAMPLE_W-1:0] exp_s;
    logic                       in_fire;
    logic                       out_fire;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    in_taken <= in_fire;
    if (in_fire) begin
      expected_samples.push_back(osc_tick(target_frequency_i, active_i));
    end
    if (out_fire) begin
      if (expected_samples.size() == 0) begin
        $error("sample_out beat with none expected: got %0d", sample_out_o);
        err_count++;
      end else begin
        exp_s = expected_samples.pop_front();
        if (sample_out_o !== exp_s) begin
          $error("sample_out mismatch: expected %0d, got %0d", exp_s, sample_out_o);
          err_count++;
        end
      end
    end
    if (in_fire || out_fire || cfg_we_i) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_smoothed_sine_oscillator NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // field extremes and walking patterns at the reset settings
    push_tick('0, 1'b0);
    push_tick('1, 1'b0);
    push_tick('1, 1'b1);
    push_tick('0, 1'b1);
    push_tick(RST_INIT_FREQ, 1'b1);
    push_tick(22'h2AAAAA, 1'b1);
    push_tick(22'h155555, 1'b0);
    push_tick(22'h000001, 1'b1);
    push_tick(22'h200000, 1'b1);
    for (int i = 0; i < 8; i++) begin
      push_tick(22'd110 << 8, 1'b1);
    end
    push_tick(22'd440 << 8, 1'b0);
    push_tick(22'd440 << 8, 1'b0);
    queue_random(280);
    drain();

    // all-ones writes: widest coefficients, top phase step, masked upper bits
    write_all('1, '1, '1, '1, '1);
    queue_random(300);
    drain();

    // all zero: frozen smoothing and a phase that stays put
    write_all('0, '0, '0, '0, '0);
    for (int i = CFG_INIT_FREQ + 1; i < 2 ** CFG_IDX_W; i++) begin
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom()));
    end
    queue_random(150);
    drain();

    write_all(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
              CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
    queue_random(300);
    drain();

    write_all(24'd32767, 24'd2000, 24'd3000, 24'(RST_PHASE_STEP), 24'(RST_INIT_FREQ));
    queue_random(300);
    drain();

    write_all(CFG_DATA_W'($urandom_range(16384, 32767)), CFG_DATA_W'($urandom_range(0, 65535)),
              CFG_DATA_W'($urandom_range(1000, 65535)), CFG_DATA_W'($urandom()),
              CFG_DATA_W'($urandom()));
    queue_random(150);
    drain();

    if (err_count == 0) begin
      $display("tb_smoothed_sine_oscillator OK");
    end else begin
      $display("tb_smoothed_sine_oscillator NOT OK");
    end
    $finish;
  end

endmodule

@@ smoothed_sine_oscillator.f @@
sv/sso_pkg.sv
sv/sso_rom.sv
sv/sso_useq.sv
sv/sso_dp.sv
sv/smoothed_sine_oscillator.sv
sv/sso_checker.sv
verif/tb_smoothed_sine_oscillator.sv
